// ===== rtl/btv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btv_pkg
// Shared constants, types and a helper function of the regularization window.
// ----------------------------------------------------------------------------
package btv_pkg;

   localparam int DEF_MAX_RADIUS  = 3;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_PIXEL_BITS  = 16;
   localparam int DEF_WEIGHT_BITS = 16;
   localparam int OUT_BITS        = 22;
   localparam int NCH             = 3;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_RADIUS = 3'd0;
   localparam logic [2:0] REG_ALPHA  = 3'd1;
   localparam logic [2:0] REG_WIDTH  = 3'd2;
   localparam logic [2:0] REG_HEIGHT = 3'd3;
   localparam logic [2:0] REG_COLOR  = 3'd4;

   // Reset values of the registers.
   localparam logic [1:0]  RST_RADIUS = 2'd3;
   localparam logic [15:0] RST_ALPHA  = 16'd22938;
   localparam logic [10:0] RST_WIDTH  = 11'd640;
   localparam logic [12:0] RST_HEIGHT = 13'd480;

   // Effective configuration handed from the register file to the datapath.
   typedef struct packed {
      logic [2:0]  radius;
      logic [13:0] width;
      logic [12:0] height;
      logic        color;
   } cfg_type;

   // Sign of a difference: +1, 0 or -1 as a two bit signed value.
   function automatic logic signed [1:0] sgn_cmp(input logic [31:0] x, input logic [31:0] y);
      logic signed [1:0] s;
      s = (x > y) ? 2'sd1 : ((x < y) ? -2'sd1 : 2'sd0);
      return s;
   endfunction

endpackage

// ===== rtl/btv_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btv_csr
// Configuration registers with clamping, and the weight table. The weights
// are rebuilt one power per cycle after reset and after every alpha write.
// ----------------------------------------------------------------------------
module btv_csr import btv_pkg::*; #(
   parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg,
   output logic [2*MAX_RADIUS:0][WEIGHT_BITS-1:0] weights
);
   localparam int SPAN = 2 * MAX_RADIUS + 1;
   localparam int FRAC = WEIGHT_BITS - 1;
   localparam int DW   = $clog2(SPAN + 1);

   logic [1:0]  radius_ff;
   logic [15:0] alpha_ff;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic        color_ff;
   logic [SPAN-1:0][WEIGHT_BITS-1:0] wt_ff, wt_in;
   logic [DW-1:0] wcnt_ff, wcnt_in;
   logic [WEIGHT_BITS-1:0] wa;
   logic [2:0] idx;
   logic       wr;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RST_RADIUS;
         alpha_ff  <= RST_ALPHA;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         color_ff  <= 1'b0;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         case (idx)
            REG_RADIUS: radius_ff <= csr_pwdata[1:0];
            REG_ALPHA:  alpha_ff  <= csr_pwdata[15:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            REG_COLOR:  color_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (idx)
         REG_RADIUS: csr_prdata = {30'd0, radius_ff};
         REG_ALPHA:  csr_prdata = {16'd0, alpha_ff};
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {19'd0, height_ff};
         REG_COLOR:  csr_prdata = {31'd0, color_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // Clamped configuration.
   always_comb begin
      logic [13:0] w;
      w = {3'd0, width_ff};
      if (radius_ff == 2'd0) cfg.radius = 3'd1;
      else if (32'(radius_ff) > MAX_RADIUS) cfg.radius = 3'(MAX_RADIUS);
      else cfg.radius = {1'b0, radius_ff};
      if (w < 14'd3) cfg.width = 14'd3;
      else if (32'(w) > MAX_WIDTH) cfg.width = 14'(MAX_WIDTH);
      else cfg.width = w;
      if (height_ff < 13'd3) cfg.height = 13'd3;
      else if (height_ff > 13'd4096) cfg.height = 13'd4096;
      else cfg.height = height_ff;
      cfg.color = color_ff;
   end

   // Alpha scaled to the weight format.
   always_comb begin
      logic [16:0] a;
      logic [47:0] t;
      a = {1'b0, alpha_ff};
      if (a < 17'd1) a = 17'd1;
      if (a > 17'd32768) a = 17'd32768;
      if (FRAC >= 15) t = 48'(a) << (FRAC - 15);
      else t = (48'(a) + (48'd1 << (14 - FRAC))) >> (15 - FRAC);
      wa = WEIGHT_BITS'(t);
   end

   // Sequential weight build: one multiply per cycle.
   always_comb begin
      logic [2*WEIGHT_BITS-1:0] p;
      wt_in   = wt_ff;
      wcnt_in = wcnt_ff;
      p = '0;
      if (wr && idx == REG_ALPHA && csr_paddr[1:0] == 2'b00) begin
         wcnt_in = DW'(1);
      end else if (32'(wcnt_ff) != 0 && 32'(wcnt_ff) < SPAN) begin
         p = wt_ff[wcnt_ff - DW'(1)] * wa + ((2*WEIGHT_BITS)'(1) << (FRAC - 1));
         wt_in[wcnt_ff] = WEIGHT_BITS'(p >> FRAC);
         wcnt_in = wcnt_ff + DW'(1);
      end
      wt_in[0] = WEIGHT_BITS'(1) << FRAC;
   end

   // The table starts from w[0] = 1.0 so that the first rebuild step is valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= DW'(1);
         wt_ff   <= (SPAN*WEIGHT_BITS)'(1) << FRAC;
      end else begin
         wcnt_ff <= wcnt_in;
         wt_ff   <= wt_in;
      end
   end

   assign weights = wt_ff;
endmodule

// ===== rtl/btv_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btv_line_mem
// Line store: one wide word per column holding one slot per stored row for
// all channels. Each column is read and written back with one slot replaced.
// ----------------------------------------------------------------------------
module btv_line_mem import btv_pkg::*; #(
   parameter int DEPTH = DEF_MAX_WIDTH,
   parameter int DW    = 96
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data
);
   logic [DW-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/btv_kernel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btv_kernel
// Sign and weight sum of one channel over the window, in two stages: the
// terms are formed and added per row, then the row sums are added.
// ----------------------------------------------------------------------------
module btv_kernel import btv_pkg::*; #(
   parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
   parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic clock,
   input  logic en,
   input  logic [2:0] radius,
   input  logic [2*MAX_RADIUS:0][WEIGHT_BITS-1:0] weights,
   input  logic [2*MAX_RADIUS:0][2*MAX_RADIUS:0][PIXEL_BITS-1:0] win,
   output logic signed [OUT_BITS-1:0] sum
);
   localparam int AB   = WEIGHT_BITS + 8;

   logic signed [MAX_RADIUS:0][AB-1:0] row_ff;

   // Stage one: terms of each row m, summed.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m <= MAX_RADIUS; m++) begin
            logic signed [AB-1:0] acc;
            logic [PIXEL_BITS-1:0] ctr, fwd, bwd;
            logic signed [2:0] t;
            int al, r;
            acc = '0;
            r = int'(radius);
            ctr = win[r][r];
            for (int l = MAX_RADIUS; l >= -MAX_RADIUS; l--) begin
               al = (l < 0) ? -l : l;
               if (m <= r && l <= r && l + m >= 0) begin
                  fwd = win[r - m][r - l];
                  bwd = win[r + m][r + l];
                  t = 3'(sgn_cmp(32'(ctr), 32'(fwd))) - 3'(sgn_cmp(32'(bwd), 32'(ctr)));
                  acc = acc + AB'($signed({1'b0, weights[m + al]})) * AB'(t);
               end
            end
            row_ff[m] <= acc;
         end
      end
   end

   // Stage two: row sums added and saturated. Each row sum is signed.
   always_comb begin
      logic signed [AB+3:0] tot;
      tot = '0;
      for (int m = 0; m <= MAX_RADIUS; m++) tot = tot + (AB+4)'($signed(row_ff[m]));
      if (tot > (AB+4)'((64'sd1 <<< (OUT_BITS - 1)) - 1))
         sum = OUT_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 1);
      else if (tot < -(AB+4)'(64'sd1 <<< (OUT_BITS - 1)))
         sum = OUT_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));
      else sum = OUT_BITS'(tot);
   end
endmodule

// ===== rtl/btv_regularization_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btv_regularization_window
// Bilateral total variation regularization over a raster pixel stream.
// ----------------------------------------------------------------------------
// When the output does not stall, one pixel is taken per clock; the result
// of the center R rows and R columns back passes the stage 0, window and
// kernel row sum registers. The rate is set by the line store, which is read
// and written once per pixel at the column address, with a forwarding path
// for back to back accesses. Border pixels give no transaction. After reset
// and after an alpha write the weight table is rebuilt. There is no clearing
// pass: stale line store contents never reach a result.
module btv_regularization_window import btv_pkg::*; #(
   parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pixel_ch0, pixel_ch1, pixel_ch2 from bit 0 up
   input  logic [((3*PIXEL_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // reg_ch0, reg_ch1, reg_ch2 from bit 0 up
   output logic [71:0] rsp_tdata,
   // frame_last
   output logic rsp_tlast,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int SPAN  = 2 * MAX_RADIUS + 1;
   localparam int LINES = 2 * MAX_RADIUS;
   localparam int PB    = PIXEL_BITS;
   localparam int LW    = LINES * NCH * PB;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int SW    = $clog2(LINES);

   cfg_type cfg;
   logic [SPAN-1:0][WEIGHT_BITS-1:0] weights;

   btv_csr #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH),
             .WEIGHT_BITS(WEIGHT_BITS)) u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg, .weights);

   // Pipeline flow: advance when the output slot is free or being taken.
   logic adv;
   logic acc_in;
   logic v0_ff, v1_ff, v2_ff;
   logic e0_ff, e1_ff, e2_ff;
   logic l0_ff, l1_ff, l2_ff;
   assign adv        = !v2_ff || rsp_tready || !e2_ff;
   assign req_tready = adv;
   assign acc_in     = req_tvalid && req_tready;

   // Position counters. The slot counter tracks the row number modulo the
   // number of stored rows and picks the line store slot of the current row.
   logic [13:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic [SW-1:0] slot_ff, slot_in, sl;
   logic [13:0] c;
   logic [12:0] r;
   always_comb begin
      c = col_ff; r = row_ff; sl = slot_ff;
      if (col_ff >= cfg.width || row_ff >= cfg.height) begin
         c = '0; r = '0; sl = '0;
      end
      col_in = c + 14'd1; row_in = r; slot_in = sl;
      if (c + 14'd1 >= cfg.width) begin
         col_in = '0;
         row_in = (r + 13'd1 >= cfg.height) ? 13'd0 : r + 13'd1;
         if (r + 13'd1 >= cfg.height || sl == SW'(LINES - 1)) slot_in = '0;
         else slot_in = sl + SW'(1);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; slot_ff <= '0;
      end else if (acc_in) begin
         col_ff <= col_in; row_ff <= row_in; slot_ff <= slot_in;
      end
   end

   // Stage 0: issue the line store read; hold the pixel.
   logic [NCH-1:0][PB-1:0] pix0_ff;
   logic [AW-1:0] a0_ff;
   logic [SW-1:0] s0_ff;
   logic [LW-1:0] rd_data, wr_data, lines_cur;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= acc_in;
      end
      if (adv) begin
         pix0_ff <= req_tdata[NCH*PB-1:0];
         a0_ff   <= c[AW-1:0];
         s0_ff   <= sl;
         e0_ff   <= acc_in && (32'(r) >= 2*int'(cfg.radius)) && (32'(c) >= 2*int'(cfg.radius));
         l0_ff   <= (r == cfg.height - 13'd1) && (c == cfg.width - 14'd1);
      end
   end

   btv_line_mem #(.DEPTH(MAX_WIDTH), .DW(LW)) u_mem (
      .clock, .rd_en(adv), .rd_addr(c[AW-1:0]), .rd_data,
      .wr_en, .wr_addr, .wr_data);

   // Forward the last written word when the same column is read back.
   logic fwd_ff;
   logic [LW-1:0] fwd_data_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_ff      <= wr_en && wr_addr == c[AW-1:0];
         fwd_data_ff <= wr_data;
      end
   end
   assign lines_cur = fwd_ff ? fwd_data_ff : rd_data;

   // Write back: the column word with the slot of the current row replaced.
   logic [LINES-1:0][NCH*PB-1:0] lines_v, wr_v;
   assign lines_v = lines_cur;
   always_comb begin
      wr_v = lines_v;
      wr_v[s0_ff] = pix0_ff;
   end
   assign wr_en   = v0_ff && adv;
   assign wr_addr = a0_ff;
   assign wr_data = wr_v;

   // Column for the window: the row a back lies in slot (s0 - a) modulo LINES.
   logic [SPAN-1:1][NCH*PB-1:0] col_up;
   always_comb begin
      logic [SW-1:0] sa;
      sa = '0;
      for (int a = 1; a < SPAN; a++) begin
         sa = (s0_ff >= SW'(a)) ? s0_ff - SW'(a) : s0_ff + SW'(LINES - a);
         col_up[a] = lines_v[sa];
      end
   end

   // Window registers: column 0 is the incoming column.
   logic [SPAN-1:0][SPAN-1:0][NCH-1:0][PB-1:0] win_ff;
   always_ff @(posedge clock) begin
      if (v0_ff && adv) begin
         for (int a = 0; a < SPAN; a++) begin
            for (int b = SPAN - 1; b > 0; b--) win_ff[a][b] <= win_ff[a][b-1];
            if (a == 0) win_ff[0][0] <= pix0_ff;
            else win_ff[a][0] <= col_up[a];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= v0_ff;
      if (adv) begin
         e1_ff <= e0_ff && v0_ff;
         l1_ff <= l0_ff;
      end
   end

   // Stage 2: kernels.
   logic signed [NCH-1:0][OUT_BITS-1:0] sums;
   for (genvar k = 0; k < NCH; k++) begin : g_ch
      logic [SPAN-1:0][SPAN-1:0][PB-1:0] wk;
      always_comb begin
         for (int a = 0; a < SPAN; a++)
            for (int b = 0; b < SPAN; b++) wk[a][b] = win_ff[a][b][k];
      end
      btv_kernel #(.MAX_RADIUS(MAX_RADIUS), .PIXEL_BITS(PB),
                   .WEIGHT_BITS(WEIGHT_BITS)) u_k (
         .clock, .en(adv), .radius(cfg.radius), .weights, .win(wk), .sum(sums[k]));
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         e2_ff <= e1_ff && v1_ff;
         l2_ff <= l1_ff;
      end
   end

   assign rsp_tvalid = v2_ff && e2_ff;
   assign rsp_tlast  = l2_ff;
   assign rsp_tdata  = {{(72 - NCH*OUT_BITS){1'b0}},
                        cfg.color ? sums[2] : {OUT_BITS{1'b0}},
                        cfg.color ? sums[1] : {OUT_BITS{1'b0}}, sums[0]};
endmodule

// ===== rtl/btv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btv_checker
// Port level checks of the regularization window.
// ----------------------------------------------------------------------------
module btv_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic csr_pready
);
   // A stalled result transaction holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input is taken whenever the output is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with free output");

   // Configuration port never waits.
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   // No result right after reset.
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind btv_regularization_window btv_checker u_chk (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_pready);
